@@ hw/rtl/toic_pkg.sv @@
// shared types and constants of the tensor order index converter
package toic_pkg;

   localparam int NDIM      = 5;
   localparam int DIM_W     = 16;
   localparam int WORD_W    = 32;
   localparam int REM_W     = WORD_W + 1;
   localparam int RANK_W    = 3;
   localparam int EB_W      = 5;
   localparam int DIV_STEPS = WORD_W;
   localparam int REQ_DW    = 120;
   localparam int RSP_DW    = 192;
   localparam int CSR_IW    = 3;

   typedef enum logic [1:0] {
      OP_SUB2IND = 2'd0,
      OP_IND2SUB = 2'd1,
      OP_STRIDE  = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   typedef enum logic [CSR_IW-1:0] {
      REG_RANK  = 3'd0,
      REG_ORDER = 3'd1,
      REG_SIZE0 = 3'd2,
      REG_SIZE1 = 3'd3,
      REG_SIZE2 = 3'd4,
      REG_SIZE3 = 3'd5,
      REG_SIZE4 = 3'd6,
      REG_NONE  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [RANK_W-1:0]                rnk;
      logic [NDIM-1:0][RANK_W-1:0]      perm;
      logic [NDIM-1:0][DIM_W-1:0]       size;
   } cfg_type;

   // one item in flight, per-position arrays indexed by memory position
   typedef struct packed {
      opcode_type                       op;
      logic [RANK_W-1:0]                rnk;
      logic                             status;
      logic [NDIM-1:0]                  posok;
      logic [NDIM-1:0]                  named;
      logic [NDIM-1:0][RANK_W-1:0]      dims;
      logic [NDIM-1:0][DIM_W-1:0]       sz;
      logic [NDIM-1:0][DIM_W-1:0]       cc;
      logic [WORD_W-1:0]                cur;
      logic [WORD_W-1:0]                acc;
      logic [NDIM-1:0][WORD_W-1:0]      strd;
      logic [WORD_W-1:0]                dvd;
      logic [NDIM-1:0][WORD_W-1:0]      quo;
      logic [NDIM-1:0][REM_W-1:0]       rem;
      logic [EB_W-1:0]                  eb;
   } item_type;

endpackage

@@ hw/rtl/toic_prep.sv @@
// entry cell: decodes a request against the configuration
module toic_prep (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         valid_up,
   input  logic [toic_pkg::REQ_DW-1:0]  tdata_up,
   input  logic [1:0]                   tuser_up,
   input  toic_pkg::cfg_type            cfg,
   output logic                         ready_up,
   output logic                         valid_ff,
   output toic_pkg::item_type           item_ff,
   input  logic                         ready_dn
);

   toic_pkg::item_type                               item_in;
   logic [toic_pkg::RANK_W-1:0]                      r;
   logic [toic_pkg::NDIM-1:0][toic_pkg::DIM_W-1:0]   coord;

   assign ready_up = !valid_ff || ready_dn;

   always_comb begin
      if (cfg.rnk == '0) begin
         r = toic_pkg::RANK_W'(1);
      end else if (cfg.rnk > toic_pkg::RANK_W'(toic_pkg::NDIM)) begin
         r = toic_pkg::RANK_W'(toic_pkg::NDIM);
      end else begin
         r = cfg.rnk;
      end
      for (int d = 0; d < toic_pkg::NDIM; d++) begin
         coord[d] = tdata_up[d*toic_pkg::DIM_W +: toic_pkg::DIM_W];
      end
      item_in        = '0;
      item_in.op     = toic_pkg::opcode_type'(tuser_up);
      item_in.rnk    = r;
      item_in.cur    = toic_pkg::WORD_W'(1);
      item_in.dvd    = tdata_up[toic_pkg::NDIM*toic_pkg::DIM_W +: toic_pkg::WORD_W];
      item_in.eb     = tdata_up[toic_pkg::NDIM*toic_pkg::DIM_W + toic_pkg::WORD_W +:
                                toic_pkg::EB_W];
      for (int p = 0; p < toic_pkg::NDIM; p++) begin
         item_in.dims[p]  = cfg.perm[p];
         item_in.posok[p] = toic_pkg::RANK_W'(p) < r;
         item_in.named[p] = item_in.posok[p] && (cfg.perm[p] < r);
         if (item_in.named[p]) begin
            item_in.sz[p] = cfg.size[cfg.perm[p]];
            item_in.cc[p] = coord[cfg.perm[p]];
         end
         if (item_in.posok[p] && (item_in.cc[p] >= item_in.sz[p])) begin
            item_in.status = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_up) begin
         valid_ff <= valid_up;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_up) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ hw/rtl/toic_stride_cell.sv @@
// stride cell: handles the position in slot 0, then rotates the positions
module toic_stride_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  valid_up,
   input  toic_pkg::item_type    item_up,
   output logic                  ready_up,
   output logic                  valid_ff,
   output toic_pkg::item_type    item_ff,
   input  logic                  ready_dn
);

   toic_pkg::item_type item_in;
   toic_pkg::item_type work;

   assign ready_up = !valid_ff || ready_dn;

   always_comb begin
      work         = item_up;
      work.strd[0] = item_up.cur;
      work.cur     = toic_pkg::WORD_W'(item_up.cur * {16'd0, item_up.sz[0]});
      if (item_up.posok[0]) begin
         work.acc = item_up.acc +
                    toic_pkg::WORD_W'(item_up.cur * {16'd0, item_up.cc[0]});
      end
      item_in = work;
      for (int k = 0; k < toic_pkg::NDIM; k++) begin
         item_in.posok[k] = work.posok[(k + 1) % toic_pkg::NDIM];
         item_in.named[k] = work.named[(k + 1) % toic_pkg::NDIM];
         item_in.dims[k]  = work.dims[(k + 1) % toic_pkg::NDIM];
         item_in.sz[k]    = work.sz[(k + 1) % toic_pkg::NDIM];
         item_in.cc[k]    = work.cc[(k + 1) % toic_pkg::NDIM];
         item_in.strd[k]  = work.strd[(k + 1) % toic_pkg::NDIM];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_up) begin
         valid_ff <= valid_up;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_up) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ hw/rtl/toic_div_cell.sv @@
// divider cell: one restoring step in every position lane
module toic_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  mod_step,
   input  logic                  clear_rem,
   input  logic                  valid_up,
   input  toic_pkg::item_type    item_up,
   output logic                  ready_up,
   output logic                  valid_ff,
   output toic_pkg::item_type    item_ff,
   input  logic                  ready_dn
);

   toic_pkg::item_type            item_in;
   logic [toic_pkg::REM_W-1:0]    rbase;
   logic [toic_pkg::REM_W-1:0]    rtry;
   logic [toic_pkg::REM_W-1:0]    dsor;
   logic [toic_pkg::WORD_W-1:0]   qsrc;

   assign ready_up = !valid_ff || ready_dn;

   always_comb begin
      item_in     = item_up;
      item_in.dvd = {item_up.dvd[toic_pkg::WORD_W-2:0], 1'b0};
      rbase = '0;
      rtry  = '0;
      dsor  = '0;
      qsrc  = '0;
      for (int l = 0; l < toic_pkg::NDIM; l++) begin
         if (!mod_step) begin
            rbase = item_up.rem[l];
            dsor  = {1'b0, item_up.strd[l]};
            rtry  = {rbase[toic_pkg::WORD_W-1:0], item_up.dvd[toic_pkg::WORD_W-1]};
            if (rtry >= dsor) begin
               item_in.rem[l] = rtry - dsor;
               item_in.quo[l] = {item_up.quo[l][toic_pkg::WORD_W-2:0], 1'b1};
            end else begin
               item_in.rem[l] = rtry;
               item_in.quo[l] = {item_up.quo[l][toic_pkg::WORD_W-2:0], 1'b0};
            end
         end else begin
            // zero stride gives quotient zero
            if (clear_rem) begin
               rbase = '0;
               qsrc  = (item_up.strd[l] == '0) ? '0 : item_up.quo[l];
            end else begin
               rbase = item_up.rem[l];
               qsrc  = item_up.quo[l];
            end
            dsor = {17'd0, item_up.sz[l]};
            rtry = {rbase[toic_pkg::WORD_W-1:0], qsrc[toic_pkg::WORD_W-1]};
            item_in.quo[l] = {qsrc[toic_pkg::WORD_W-2:0], 1'b0};
            item_in.rem[l] = (rtry >= dsor) ? rtry - dsor : rtry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_up) begin
         valid_ff <= valid_up;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_up) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ hw/rtl/toic_out.sv @@
// output cell: scatters position results to dimensions and holds the response
module toic_out (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         valid_up,
   input  toic_pkg::item_type           item_up,
   output logic                         ready_up,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [toic_pkg::RSP_DW-1:0]  rsp_tdata,
   output logic [0:0]                   rsp_tuser
);

   logic [toic_pkg::RSP_DW-1:0]   data_ff;
   logic [toic_pkg::RSP_DW-1:0]   data_in;
   logic                          status_ff;
   logic                          status_in;
   logic                          valid_ff;
   logic [toic_pkg::WORD_W-1:0]   v1;
   logic [toic_pkg::WORD_W-1:0]   st;
   logic [toic_pkg::WORD_W-1:0]   v2;
   logic [toic_pkg::NDIM-1:0][toic_pkg::WORD_W-1:0] crd;

   assign ready_up   = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = status_ff;

   always_comb begin
      data_in   = '0;
      status_in = 1'b0;
      v1 = '0;
      st = '0;
      v2 = '0;
      for (int p = 0; p < toic_pkg::NDIM; p++) begin
         crd[p] = (item_up.sz[p] != '0) ? {16'd0, item_up.rem[p][toic_pkg::DIM_W-1:0]} : '0;
      end
      if (item_up.op == toic_pkg::OP_SUB2IND) begin
         status_in = item_up.status;
         data_in[toic_pkg::WORD_W-1:0] = item_up.status ? '0 : item_up.acc;
      end
      for (int d = 0; d < toic_pkg::NDIM; d++) begin
         v1 = '0;
         st = (toic_pkg::RANK_W'(d) < item_up.rnk) ? toic_pkg::WORD_W'(1) : '0;
         for (int p = 0; p < toic_pkg::NDIM; p++) begin
            if (item_up.named[p] && (item_up.dims[p] == toic_pkg::RANK_W'(d))) begin
               v1 = crd[p];
               st = item_up.strd[p];
            end
         end
         v2 = toic_pkg::WORD_W'(st * {27'd0, item_up.eb});
         if (item_up.op == toic_pkg::OP_IND2SUB) begin
            data_in[(d+1)*toic_pkg::WORD_W +: toic_pkg::WORD_W] = v1;
         end else if (item_up.op == toic_pkg::OP_STRIDE) begin
            data_in[(d+1)*toic_pkg::WORD_W +: toic_pkg::WORD_W] = v2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_up) begin
         valid_ff <= valid_up;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_up) begin
         data_ff   <= data_in;
         status_ff <= status_in;
      end
   end

endmodule

@@ hw/rtl/tensor_order_index_convert.sv @@
// Tensor address unit: converts subscripts to a linear index, a linear index to
// subscripts, or produces per-dimension strides, for a tensor of rank 1 to 5 whose
// memory order is the configured permutation of dimensions. It takes one request
// per cycle while the output is not held; every request yields one response. It is a
// row of registered cells: one entry cell, five stride cells (one multiply-accumulate
// each), 64 divider cells (32 quotient steps, then 32 remainder steps, one bit per
// cell across all five lanes) and the output register.
module tensor_order_index_convert (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [toic_pkg::REQ_DW-1:0]  req_tdata,   // coord0..coord4, linear_in, elem_bytes
   input  logic [1:0]                   req_tuser,   // opcode
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [toic_pkg::RSP_DW-1:0]  rsp_tdata,   // linear_out, value0..value4
   output logic [0:0]                   rsp_tuser,   // status
   input  logic                         csr_we,
   input  logic [toic_pkg::CSR_IW-1:0]  csr_index,
   input  logic [toic_pkg::DIM_W-1:0]   csr_wdata
);

   localparam int NSTAGE = 1 + toic_pkg::NDIM + 2 * toic_pkg::DIV_STEPS;

   toic_pkg::cfg_type   cfg_ff;
   toic_pkg::cfg_type   cfg_in;
   logic                vld [0:NSTAGE-1];
   toic_pkg::item_type  itm [0:NSTAGE-1];
   logic                rdy [0:NSTAGE];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (toic_pkg::csr_index_type'(csr_index))
            toic_pkg::REG_RANK:  cfg_in.rnk = csr_wdata[toic_pkg::RANK_W-1:0];
            toic_pkg::REG_ORDER: begin
               for (int p = 0; p < toic_pkg::NDIM; p++) begin
                  cfg_in.perm[p] = csr_wdata[p*toic_pkg::RANK_W +: toic_pkg::RANK_W];
               end
            end
            toic_pkg::REG_SIZE0: cfg_in.size[0] = csr_wdata;
            toic_pkg::REG_SIZE1: cfg_in.size[1] = csr_wdata;
            toic_pkg::REG_SIZE2: cfg_in.size[2] = csr_wdata;
            toic_pkg::REG_SIZE3: cfg_in.size[3] = csr_wdata;
            toic_pkg::REG_SIZE4: cfg_in.size[4] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rnk <= toic_pkg::RANK_W'(4);
         for (int p = 0; p < toic_pkg::NDIM; p++) begin
            cfg_ff.perm[p] <= toic_pkg::RANK_W'(p);
            cfg_ff.size[p] <= toic_pkg::DIM_W'(1);
         end
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = rdy[0];

   toic_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .valid_up (req_tvalid),
      .tdata_up (req_tdata),
      .tuser_up (req_tuser),
      .cfg      (cfg_ff),
      .ready_up (rdy[0]),
      .valid_ff (vld[0]),
      .item_ff  (itm[0]),
      .ready_dn (rdy[1])
   );

   for (genvar k = 0; k < toic_pkg::NDIM; k++) begin : g_stride
      toic_stride_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .valid_up (vld[k]),
         .item_up  (itm[k]),
         .ready_up (rdy[k+1]),
         .valid_ff (vld[k+1]),
         .item_ff  (itm[k+1]),
         .ready_dn (rdy[k+2])
      );
   end

   for (genvar i = 0; i < 2 * toic_pkg::DIV_STEPS; i++) begin : g_div
      localparam int J = 1 + toic_pkg::NDIM + i;
      toic_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .mod_step  (1'(i >= toic_pkg::DIV_STEPS)),
         .clear_rem (1'(i == toic_pkg::DIV_STEPS)),
         .valid_up  (vld[J-1]),
         .item_up   (itm[J-1]),
         .ready_up  (rdy[J]),
         .valid_ff  (vld[J]),
         .item_ff   (itm[J]),
         .ready_dn  (rdy[J+1])
      );
   end

   toic_out u_out (
      .clock      (clock),
      .reset      (reset),
      .valid_up   (vld[NSTAGE-1]),
      .item_up    (itm[NSTAGE-1]),
      .ready_up   (rdy[NSTAGE]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // back-pressure at the input only when a response is held at the output
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without output stall");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("error response carries data");

   assert property (@(posedge clock) disable iff (reset)
      $past(!csr_we) |-> $stable(cfg_ff))
      else $error("configuration changed without a write");

endmodule

@@ bench/tb.sv @@
// self-checking bench for the tensor order index converter
`timescale 1ns / 1ps

module tb;

   typedef struct {
      toic_pkg::opcode_type op;
      logic [15:0] coord [5];
      logic [31:0] lin;
      logic [4:0] eb;
   } addr_req_type;

   typedef struct {
      logic [31:0] lin;
      logic [31:0] val [5];
      logic status;
   } addr_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [toic_pkg::REQ_DW-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [toic_pkg::RSP_DW-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic csr_we = 1'b0;
   logic [toic_pkg::CSR_IW-1:0] csr_index = '0;
   logic [toic_pkg::DIM_W-1:0] csr_wdata = '0;

   tensor_order_index_convert dut (.*);

   // shadow of the configuration registers
   logic [2:0] sh_rank = 3'd4;
   logic [14:0] sh_perm = 15'd18056;
   logic [15:0] sh_size [5] = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd1};

   addr_req_type pending_reqs [$];
   addr_rsp_type expected_rsps [$];
   int errors = 0;
   int send_gap = 0;
   int recv_gap = 0;
   bit req_taken = 1'b0;

   initial forever #5 clock = ~clock;

   function automatic int gap_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 40) return 0;
      if (k < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic addr_rsp_type convert_addr(addr_req_type q);
      addr_rsp_type rs;
      int unsigned r, dd, s, c;
      logic [31:0] mul, acc, strd, quo;
      r = sh_rank == 0 ? 1 : (sh_rank > 5 ? 5 : sh_rank);
      rs.lin = 0;
      rs.status = 0;
      foreach (rs.val[i]) rs.val[i] = 0;
      mul = 1;
      acc = 0;
      strd = 1;
      if (q.op == toic_pkg::OP_STRIDE)
         for (int d = 0; d < r; d++) rs.val[d] = 1;
      for (int p = 0; p < r; p++) begin
         dd = (sh_perm >> (3 * p)) & 7;
         s = dd < r ? sh_size[dd] : 0;
         c = dd < r ? q.coord[dd] : 0;
         case (q.op)
            toic_pkg::OP_SUB2IND: begin
               if (c >= s) rs.status = 1;
               acc = acc + mul * c;
               mul = mul * s;
            end
            toic_pkg::OP_IND2SUB: begin
               quo = strd != 0 ? q.lin / strd : 0;
               if (dd < r) rs.val[dd] = s != 0 ? quo % s : 0;
               strd = strd * s;
            end
            toic_pkg::OP_STRIDE: begin
               if (dd < r) rs.val[dd] = strd;
               strd = strd * s;
            end
            default: ;
         endcase
      end
      if (q.op == toic_pkg::OP_SUB2IND) rs.lin = rs.status ? 0 : acc;
      if (q.op == toic_pkg::OP_STRIDE)
         for (int d = 0; d < r; d++) rs.val[d] = rs.val[d] * q.eb;
      return rs;
   endfunction

   function automatic addr_req_type rand_req(int op);
      addr_req_type q;
      q.op = toic_pkg::opcode_type'(op);
      foreach (q.coord[d]) begin
         case ($urandom_range(0, 9))
            0: q.coord[d] = 16'($urandom);
            1: q.coord[d] = sh_size[d];
            default: q.coord[d] = sh_size[d] == 0 ? 16'd0 :
                                  16'($urandom_range(0, sh_size[d] - 1));
         endcase
      end
      case ($urandom_range(0, 3))
         0: q.lin = $urandom;
         default: q.lin = $urandom_range(0, 100000);
      endcase
      q.eb = $urandom_range(0, 4) == 0 ? 5'($urandom) : 5'($urandom_range(1, 16));
      return q;
   endfunction

   task automatic csr_write(toic_pkg::csr_index_type idx, logic [15:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx) inside
         toic_pkg::REG_RANK:  sh_rank = v[2:0];
         toic_pkg::REG_ORDER: sh_perm = v[14:0];
         [toic_pkg::REG_SIZE0:toic_pkg::REG_SIZE4]:
            sh_size[idx - toic_pkg::REG_SIZE0] = v;
         default: ;
      endcase
   endtask

   task automatic drain();
      wait (pending_reqs.size() == 0 && !req_tvalid);
      wait (expected_rsps.size() == 0);
      repeat (80) @(negedge clock);
   endtask

   function automatic logic [14:0] rand_perm(bit legal);
      int unsigned a [$] = '{0, 1, 2, 3, 4};
      logic [14:0] v;
      if (!legal) return 15'($urandom);
      a.shuffle();
      v = 0;
      foreach (a[i]) v |= 15'(a[i] << (3 * i));
      return v;
   endfunction

   // transfer seen at the rising edge
   always @(posedge clock) begin
      req_taken = req_tvalid && req_tready;
   end

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            if (send_gap > 0 || pending_reqs.size() == 0) begin
               if (send_gap > 0) send_gap--;
               req_tvalid <= 1'b0;
            end else begin
               addr_req_type q;
               q = pending_reqs.pop_front();
               req_tuser <= q.op;
               req_tdata <= {3'd0, q.eb, q.lin, q.coord[4], q.coord[3], q.coord[2],
                             q.coord[1], q.coord[0]};
               req_tvalid <= 1'b1;
               expected_rsps.push_back(convert_addr(q));
               send_gap = gap_len();
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_gap = gap_len();
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         addr_rsp_type e;
         logic [toic_pkg::RSP_DW-1:0] ed;
         if (expected_rsps.size() == 0) begin
            $display("%0t unexpected transfer data=%h status=%b", $realtime, rsp_tdata,
                     rsp_tuser);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            ed = {e.val[4], e.val[3], e.val[2], e.val[1], e.val[0], e.lin};
            for (int f = 0; f < 6; f++)
               if (rsp_tdata[32*f +: 32] !== ed[32*f +: 32]) begin
                  $display("%0t field %0d expected %h actual %h", $realtime, f,
                           ed[32*f +: 32], rsp_tdata[32*f +: 32]);
                  errors++;
               end
            if (rsp_tuser[0] !== e.status) begin
               $display("%0t status expected %b actual %b", $realtime, e.status,
                        rsp_tuser[0]);
               errors++;
            end
         end
      end
   end

   initial begin
      addr_req_type q;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // reset configuration, then directed cases
      for (int op = 0; op < 4; op++) pending_reqs.push_back(rand_req(op));
      drain();
      csr_write(toic_pkg::REG_RANK, 16'd5);
      csr_write(toic_pkg::REG_ORDER, 16'd18056);
      for (int d = 0; d < 5; d++)
         csr_write(toic_pkg::csr_index_type'(toic_pkg::REG_SIZE0 + d), 16'hFFFF);
      q = rand_req(toic_pkg::OP_SUB2IND);
      foreach (q.coord[d]) q.coord[d] = 16'hFFFE;
      pending_reqs.push_back(q);
      foreach (q.coord[d]) q.coord[d] = 16'hFFFF;
      pending_reqs.push_back(q);
      q = rand_req(toic_pkg::OP_IND2SUB); q.lin = 32'hFFFFFFFF; pending_reqs.push_back(q);
      q.lin = 0; pending_reqs.push_back(q);
      q = rand_req(toic_pkg::OP_STRIDE); q.eb = 0; pending_reqs.push_back(q);
      q.eb = 5'h1F; pending_reqs.push_back(q);
      q.eb = 16; pending_reqs.push_back(q);
      pending_reqs.push_back(rand_req(toic_pkg::OP_NONE));
      drain();
      // odd ranks and a non-permutation order, zero size
      csr_write(toic_pkg::REG_RANK, 16'd0);
      csr_write(toic_pkg::REG_ORDER, 16'h7FFF);
      csr_write(toic_pkg::REG_SIZE1, 16'd0);
      for (int op = 0; op < 4; op++) pending_reqs.push_back(rand_req(op));
      drain();
      csr_write(toic_pkg::REG_RANK, 16'd7);
      csr_write(toic_pkg::REG_ORDER, 16'b0_001_001_000_011_010);
      for (int op = 0; op < 4; op++) pending_reqs.push_back(rand_req(op));
      drain();
      csr_write(toic_pkg::REG_RANK, 16'd6);
      csr_write(toic_pkg::REG_ORDER, 16'b0_000_001_010_011_100);
      for (int op = 0; op < 3; op++) pending_reqs.push_back(rand_req(op));
      drain();
      // random phases
      for (int ph = 0; ph < 18; ph++) begin
         csr_write(toic_pkg::REG_RANK, $urandom_range(0, 9) == 0 ? 16'(3'($urandom)) :
                                       16'($urandom_range(1, 5)));
         csr_write(toic_pkg::REG_ORDER, 16'(rand_perm($urandom_range(0, 4) != 0)));
         for (int d = 0; d < 5; d++)
            csr_write(toic_pkg::csr_index_type'(toic_pkg::REG_SIZE0 + d),
                      $urandom_range(0, 7) == 0 ? 16'($urandom) :
                      ($urandom_range(0, 19) == 0 ? 16'd0 : 16'($urandom_range(1, 40))));
         for (int i = 0; i < 100; i++) begin
            q = rand_req($urandom_range(0, 19) == 0 ? toic_pkg::OP_NONE :
                         $urandom_range(0, 2));
            pending_reqs.push_back(q);
            if (i == 50) begin
               wait (pending_reqs.size() == 0);
               wait (expected_rsps.size() == 0);
            end
         end
         drain();
      end
      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule

@@ sim.f @@
hw/rtl/toic_pkg.sv
hw/rtl/toic_prep.sv
hw/rtl/toic_stride_cell.sv
hw/rtl/toic_div_cell.sv
hw/rtl/toic_out.sv
hw/rtl/tensor_order_index_convert.sv
bench/tb.sv
